/* src/grid_ray_traversal_macros.svh */
// Assertion macros used by the checker file of the grid ray traversal block.
`ifndef GRID_RAY_TRAVERSAL_MACROS_SVH
`define GRID_RAY_TRAVERSAL_MACROS_SVH

// Same-cycle implication under synchronous active-low reset
`define GRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset
`define GRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/grt_pkg.sv */
// Shared types, constants and helper functions of the grid ray traversal block.
`default_nettype none
package grt_pkg;

  localparam int MAX_CELLS = 64;
  localparam int NCNT_W    = $clog2(MAX_CELLS);

  localparam int DVD_W  = 48;   // divider dividend / quotient width
  localparam int DVS_W  = 32;   // divider divisor / remainder width
  localparam int CNT_W  = 6;    // divider iteration counter width

  localparam logic [CNT_W-1:0] ITER_FLOOR = CNT_W'(32);
  localparam logic [CNT_W-1:0] ITER_TIME  = CNT_W'(46);

  localparam logic [31:0] TIME_INF = 32'hFFFF_FFFF;
  localparam logic [30:0] CS_RESET = 31'd65536;

  localparam int CELL_IW = 34;  // exact internal cell index width

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // Clamp an exact cell index to the 24-bit output range
  function automatic logic [23:0] cell_sat(input logic signed [CELL_IW-1:0] c);
    logic signed [CELL_IW-1:0] hi;
    logic signed [CELL_IW-1:0] lo;
    hi = CELL_IW'(8388607);
    lo = -CELL_IW'(8388608);
    if (c > hi) return 24'h7F_FFFF;
    else if (c < lo) return 24'h80_0000;
    else return c[23:0];
  endfunction

  // Saturate a 48-bit quotient to a 32-bit time
  function automatic logic [31:0] time_sat(input logic [DVD_W-1:0] q);
    if (q[DVD_W-1:32] != '0) return TIME_INF;
    else return q[31:0];
  endfunction

endpackage
`default_nettype wire

/* src/grt_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module grt_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire grt_pkg::div_req_t        req,
  output logic                          done,
  output logic [grt_pkg::DVD_W-1:0]     quot,
  output logic [grt_pkg::DVS_W-1:0]     rem
);
  import grt_pkg::*;

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [DVS_W:0]   rem_sh;
  logic             qbit;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs_r});
  end

  // Control: load on start, count down, pulse done on the final bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift quotient bits into the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= qbit ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* src/grid_ray_traversal.sv */
// Top level: 2D grid ray walk, setup on a shared divider, then one cell per cycle.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | tvalid/tready      | tdata: origin_x, origin_y, dir_x, dir_y,
//          |     |                    |        max_distance
//  out_    | out | tvalid/tready      | tdata: cell_x, cell_y; tlast: last;
//          |     |                    | tuser: truncated
//  cfg_    | in  | valid/ready        | data: cell_size (always ready)
//
// Setup runs six serial divisions on one shared divider: two for the start
// cell and four for crossing times; an axis with zero direction skips its two.
// The walk then emits one cell per cycle unless the output stalls; the item
// is done after at most 64 cells. in_tready is high only between rays.
// Reset (rst_n low, synchronous) sets cell_size to 1.0 and empties the output.
`default_nettype none
module grid_ray_traversal (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [31:0] origin_x, [63:32] origin_y, [79:64] dir_x, [95:80] dir_y,
  // [126:96] max_distance, [127] zero
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [23:0] cell_x, [47:24] cell_y
  output logic [47:0]       out_tdata,
  output logic              out_tlast,
  // [0] truncated
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [30:0]  cfg_data
);
  import grt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_OX, S_OY, S_TNX, S_TDX, S_TNY, S_TDY, S_WALK
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      start_r, start_nxt;
  logic [30:0]               cs_r;
  logic [30:0]               cs_eff;
  logic signed [31:0]        ox_r, oy_r;
  logic signed [15:0]        dx_r, dy_r;
  logic [30:0]               maxd_r;
  logic signed [CELL_IW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [30:0]               frx_r, frx_nxt, fry_r, fry_nxt;
  logic [31:0]               tx_r, tx_nxt, ty_r, ty_nxt;
  logic [31:0]               ddx_r, ddx_nxt, ddy_r, ddy_nxt;
  logic [NCNT_W-1:0]         n_r, n_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [47:0]               out_data_r, out_data_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_trunc_r, out_trunc_nxt;

  div_req_t                  req;
  logic                      div_done;
  logic [DVD_W-1:0]          div_q;
  logic [DVS_W-1:0]          div_rem;

  logic                      accept, emit;
  logic [31:0]               abs_org;
  logic                      org_neg;
  logic [15:0]               mag_x, mag_y;
  logic [30:0]               diff_x, diff_y;
  logic signed [CELL_IW-1:0] floor_q;
  logic [30:0]               floor_fr;
  logic                      x_step, past_max, at_limit, last_w;
  logic [31:0]               t_new;
  logic [32:0]               sum_x, sum_y;

  assign cs_eff    = (cs_r == '0) ? 31'd1 : cs_r;
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Magnitudes and distances to the first boundary
  assign mag_x  = dx_r[15] ? 16'(-dx_r) : 16'(dx_r);
  assign mag_y  = dy_r[15] ? 16'(-dy_r) : 16'(dy_r);
  assign diff_x = dx_r[15] ? frx_r : 31'(cs_eff - frx_r);
  assign diff_y = dy_r[15] ? fry_r : 31'(cs_eff - fry_r);

  // Select divider operands for the current setup step
  always_comb begin
    org_neg = (state_r == S_OY) ? oy_r[31] : ox_r[31];
    abs_org = (state_r == S_OY) ? (oy_r[31] ? 32'(-oy_r) : 32'(oy_r))
                                : (ox_r[31] ? 32'(-ox_r) : 32'(ox_r));
    req.start    = start_r;
    req.iters    = ITER_TIME;
    req.dividend = {cs_eff, 17'd0};
    req.divisor  = {16'd0, mag_x};
    case (state_r)
      S_OX, S_OY: begin
        req.iters    = ITER_FLOOR;
        req.dividend = {abs_org, 16'd0};
        req.divisor  = {1'b0, cs_eff};
      end
      S_TNX:   req.dividend = {diff_x, 17'd0};
      S_TDX:   req.dividend = {cs_eff, 17'd0};
      S_TNY: begin
        req.dividend = {diff_y, 17'd0};
        req.divisor  = {16'd0, mag_y};
      end
      S_TDY:   req.divisor  = {16'd0, mag_y};
      default: ;
    endcase
  end

  // Floor quotient and floor remainder from the unsigned division
  always_comb begin
    if (org_neg) begin
      floor_q  = -CELL_IW'(div_q[31:0]) - CELL_IW'(div_rem != '0);
      floor_fr = (div_rem == '0) ? 31'd0 : 31'(cs_eff - div_rem[30:0]);
    end else begin
      floor_q  = CELL_IW'(div_q[31:0]);
      floor_fr = div_rem[30:0];
    end
  end

  // Walk step: pick the axis, compute entry time and the stop condition
  always_comb begin
    x_step   = (tx_r < ty_r);
    t_new    = x_step ? tx_r : ty_r;
    past_max = (t_new > {1'b0, maxd_r});
    at_limit = (n_r == NCNT_W'(MAX_CELLS - 1));
    last_w   = past_max || at_limit;
    sum_x    = {1'b0, tx_r} + {1'b0, ddx_r};
    sum_y    = {1'b0, ty_r} + {1'b0, ddy_r};
    emit     = (state_r == S_WALK) && (!out_valid_r || out_tready);
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    frx_nxt       = frx_r;
    fry_nxt       = fry_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    ddx_nxt       = ddx_r;
    ddy_nxt       = ddy_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_OX;
          start_nxt = 1'b1;
          n_nxt     = '0;
        end
      end
      S_OX: begin
        if (div_done) begin
          cx_nxt    = floor_q;
          frx_nxt   = floor_fr;
          state_nxt = S_OY;
          start_nxt = 1'b1;
        end
      end
      S_OY: begin
        if (div_done) begin
          cy_nxt    = floor_q;
          fry_nxt   = floor_fr;
          state_nxt = S_TNX;
          start_nxt = (dx_r != '0);
        end
      end
      S_TNX: begin
        if (dx_r == '0) begin
          tx_nxt    = TIME_INF;
          ddx_nxt   = TIME_INF;
          state_nxt = S_TNY;
          start_nxt = (dy_r != '0);
        end else if (div_done) begin
          tx_nxt    = time_sat(div_q);
          state_nxt = S_TDX;
          start_nxt = 1'b1;
        end
      end
      S_TDX: begin
        if (div_done) begin
          ddx_nxt   = time_sat(div_q);
          state_nxt = S_TNY;
          start_nxt = (dy_r != '0);
        end
      end
      S_TNY: begin
        if (dy_r == '0) begin
          ty_nxt    = TIME_INF;
          ddy_nxt   = TIME_INF;
          state_nxt = S_WALK;
        end else if (div_done) begin
          ty_nxt    = time_sat(div_q);
          state_nxt = S_TDY;
          start_nxt = 1'b1;
        end
      end
      S_TDY: begin
        if (div_done) begin
          ddy_nxt   = time_sat(div_q);
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {cell_sat(cy_r), cell_sat(cx_r)};
          out_last_nxt  = last_w;
          out_trunc_nxt = last_w && !past_max;
          n_nxt         = n_r + NCNT_W'(1);
          if (x_step) begin
            cx_nxt = dx_r[15] ? cx_r - CELL_IW'(1) : cx_r + CELL_IW'(1);
            tx_nxt = sum_x[32] ? TIME_INF : sum_x[31:0];
          end else begin
            cy_nxt = dy_r[15] ? cy_r - CELL_IW'(1) : cy_r + CELL_IW'(1);
            ty_nxt = sum_y[32] ? TIME_INF : sum_y[31:0];
          end
          if (last_w) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cs_r        <= CS_RESET;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      if (cfg_valid) cs_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ox_r   <= in_tdata[31:0];
      oy_r   <= in_tdata[63:32];
      dx_r   <= in_tdata[79:64];
      dy_r   <= in_tdata[95:80];
      maxd_r <= in_tdata[126:96];
    end
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    frx_r       <= frx_nxt;
    fry_r       <= fry_nxt;
    tx_r        <= tx_nxt;
    ty_r        <= ty_nxt;
    ddx_r       <= ddx_nxt;
    ddy_r       <= ddy_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  grt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .done  (div_done),
    .quot  (div_q),
    .rem   (div_rem)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_trunc_r;

endmodule
`default_nettype wire

/* src/grt_checker.sv */
// Port-level checker for the grid ray traversal top level, with its bind.
`default_nettype none
`include "grid_ray_traversal_macros.svh"
module grt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [0:0]  out_tuser
);

  // A ray occupies the block after it is taken
  `GRT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "block ready right after taking a ray")

  // Truncation is flagged only on the final cell
  `GRT_ASSERT_NOW(a_trunc_on_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast, "truncated set on a cell that is not last")

  // Stalled output item stays offered
  `GRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "output item dropped while stalled")

  // Stalled output item keeps its data
  `GRT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "output item changed while stalled")

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire
